// ----- sv/brfms_pkg.sv -----
package brfms_pkg;

  // Processor mode codes.
  localparam logic [4:0] MODE_USR = 5'h10;
  localparam logic [4:0] MODE_FIQ = 5'h11;
  localparam logic [4:0] MODE_IRQ = 5'h12;
  localparam logic [4:0] MODE_SVC = 5'h13;
  localparam logic [4:0] MODE_ABT = 5'h17;
  localparam logic [4:0] MODE_UND = 5'h1B;
  localparam logic [4:0] MODE_SYS = 5'h1F;

  // Start values of the visible registers.
  localparam logic [31:0] RST_PC    = 32'h0800_0000;
  localparam logic [31:0] RST_R1    = 32'h0000_00EA;
  localparam logic [31:0] RST_SP    = 32'h0300_7F00;

  // Bank geometry.
  localparam int NumRegs   = 16;
  localparam int NumHigh   = 5;
  localparam int NumBanks  = 6;
  localparam int NumSaved  = 5;

  // Operation codes of an item.
  typedef enum logic [2:0] {
    K_READ_REG  = 3'd0,
    K_WRITE_REG = 3'd1,
    K_MODE      = 3'd2,
    K_READ_SPSR = 3'd3,
    K_WRITE_SPSR = 3'd4
  } kind_t;

  // Controller states.
  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic execute;
  } cmd_t;

  // Bank slot of a mode code.
  typedef struct packed {
    logic       ok;
    logic [2:0] idx;
  } slot_t;

  function automatic slot_t mode_slot(logic [4:0] m);
    slot_t s;
    s.ok  = 1'b1;
    s.idx = 3'd0;
    case (m)
      MODE_USR, MODE_SYS: s.idx = 3'd0;
      MODE_FIQ: s.idx = 3'd1;
      MODE_IRQ: s.idx = 3'd2;
      MODE_SVC: s.idx = 3'd3;
      MODE_ABT: s.idx = 3'd4;
      MODE_UND: s.idx = 3'd5;
      default: s.ok = 1'b0;
    endcase
    return s;
  endfunction

endpackage

// ----- sv/brfms_ctrl.sv -----
module brfms_ctrl
  import brfms_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output cmd_t cmd
);

  state_t state;
  state_t state_next;
  logic   out_full;
  logic   out_full_next;

  // State register and output-full flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      out_full <= 1'b0;
    end else begin
      state    <= state_next;
      out_full <= out_full_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next    = state;
    in_ready      = 1'b0;
    cmd.capture   = 1'b0;
    cmd.execute   = 1'b0;
    out_full_next = out_full && !out_ready;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // The result may only be written once the output register is free.
        if (!out_full || out_ready) begin
          cmd.execute   = 1'b1;
          out_full_next = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign out_valid = out_full;

endmodule

// ----- sv/brfms_dp.sv -----
module brfms_dp
  import brfms_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  input  logic [2:0]  kind,
  input  logic [3:0]  reg_index,
  input  logic [31:0] write_value,
  input  logic [4:0]  target_mode,
  output logic [31:0] read_value,
  output logic [4:0]  mode_now,
  output logic        error
);

  // Captured item.
  logic [2:0]  cap_kind;
  logic [3:0]  cap_idx;
  logic [31:0] cap_val;
  logic [4:0]  cap_mode;

  // Architectural state.
  logic [31:0] regs [NumRegs];
  logic [31:0] shadow [NumHigh];
  logic [31:0] bank_sp [NumBanks];
  logic [31:0] bank_lr [NumBanks];
  logic [31:0] bank_spsr [NumSaved];
  logic [31:0] spsr;
  logic [4:0]  cur_mode;

  slot_t       from_slot;
  slot_t       to_slot;
  logic        has_spsr;
  logic        do_switch;
  logic        fiq_cross;
  logic [31:0] sp_in;
  logic [31:0] lr_in;
  logic [31:0] rd;
  logic        err;
  logic [4:0]  mode_after;

  // Hold the accepted item.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cap_kind <= kind;
      cap_idx  <= reg_index;
      cap_val  <= write_value;
      cap_mode <= target_mode;
    end
  end

  // Decode of the captured operation.
  always_comb begin
    from_slot  = mode_slot(cur_mode);
    to_slot    = mode_slot(cap_mode);
    has_spsr   = from_slot.ok && (from_slot.idx != 3'd0);
    do_switch  = (cap_kind == K_MODE) && to_slot.ok && (cap_mode != cur_mode);
    fiq_cross  = (cur_mode == MODE_FIQ) != (cap_mode == MODE_FIQ);
    // User and system share a bank, so r13 and r14 stay as they are.
    sp_in      = (from_slot.idx == to_slot.idx) ? regs[13] : bank_sp[to_slot.idx];
    lr_in      = (from_slot.idx == to_slot.idx) ? regs[14] : bank_lr[to_slot.idx];
    rd         = '0;
    err        = 1'b0;
    mode_after = do_switch ? cap_mode : cur_mode;
    case (cap_kind)
      K_READ_REG:   rd = regs[cap_idx];
      K_WRITE_REG:  rd = '0;
      K_MODE:       err = !to_slot.ok;
      K_READ_SPSR: begin
        if (has_spsr) begin
          rd = spsr;
        end else begin
          err = 1'b1;
        end
      end
      K_WRITE_SPSR: err = !has_spsr;
      default:      rd = '0;
    endcase
  end

  // State update on execute.
  always_ff @(posedge clk) begin
    if (rst) begin
      // Start values: r0 and r15 hold the entry point, r1 and r13 their own.
      for (int i = 0; i < NumRegs; i++) begin
        if (i == 0 || i == 15) begin
          regs[i] <= RST_PC;
        end else if (i == 1) begin
          regs[i] <= RST_R1;
        end else if (i == 13) begin
          regs[i] <= RST_SP;
        end else begin
          regs[i] <= '0;
        end
      end
      for (int i = 0; i < NumHigh; i++) begin
        shadow[i] <= '0;
      end
      for (int i = 0; i < NumBanks; i++) begin
        bank_sp[i] <= '0;
        bank_lr[i] <= '0;
      end
      for (int i = 0; i < NumSaved; i++) begin
        bank_spsr[i] <= '0;
      end
      spsr     <= '0;
      cur_mode <= MODE_SYS;
    end else if (cmd.execute) begin
      if (cap_kind == K_WRITE_REG) begin
        regs[cap_idx] <= cap_val;
      end
      if (cap_kind == K_WRITE_SPSR && has_spsr) begin
        spsr <= cap_val;
      end
      if (do_switch) begin
        // Save the outgoing bank, then load the incoming one.
        bank_sp[from_slot.idx] <= regs[13];
        bank_lr[from_slot.idx] <= regs[14];
        if (from_slot.idx != 3'd0) begin
          bank_spsr[from_slot.idx - 3'd1] <= spsr;
        end
        if (fiq_cross) begin
          for (int i = 0; i < NumHigh; i++) begin
            regs[8 + i] <= shadow[i];
            shadow[i]   <= regs[8 + i];
          end
        end
        regs[13] <= sp_in;
        regs[14] <= lr_in;
        if (to_slot.idx != 3'd0) begin
          spsr <= bank_spsr[to_slot.idx - 3'd1];
        end
        cur_mode <= cap_mode;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      read_value <= rd;
      mode_now   <= mode_after;
      error      <= err;
    end
  end

endmodule

// ----- sv/banked_register_file_mode_switch.sv -----
// Channel   Handshake              Payload
// in        in_valid / in_ready    kind, reg_index, write_value, target_mode
// out       out_valid / out_ready  read_value, mode_now, error
//
// An item is captured in ST_IDLE and executed in ST_EXEC, so the block takes no
// new item until the last one has executed; the two-state controller sets that.
// The result sits in an output register, so the next item is taken while it
// waits. An item waits in execution only while the previous result is unread.
// Reset clears the handshake state and loads the start register values.
module banked_register_file_mode_switch
  import brfms_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  kind,
  input  logic [3:0]  reg_index,
  input  logic [31:0] write_value,
  input  logic [4:0]  target_mode,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] read_value,
  output logic [4:0]  mode_now,
  output logic        error
);

  cmd_t cmd;

  // Sequencing of items.
  brfms_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // Register banks and result register.
  brfms_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .kind        (kind),
    .reg_index   (reg_index),
    .write_value (write_value),
    .target_mode (target_mode),
    .read_value  (read_value),
    .mode_now    (mode_now),
    .error       (error)
  );

  // A reported mode is always a legal mode code.
  a_mode_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> mode_slot(mode_now).ok)
    else $error("illegal mode reported");

  // An erroring item never returns data.
  a_err_no_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && error |-> read_value == '0)
    else $error("error with nonzero read value");

  // One item in flight: no accept right after an accept.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second item accepted while busy");

  // Execution always yields a pending result.
  a_exec_result: assert property (@(posedge clk) disable iff (rst)
    cmd.execute |=> out_valid)
    else $error("executed item lost");

endmodule

// ----- tb/sv/banked_register_file_mode_switch_tb.sv -----
`timescale 1ns / 100ps

module banked_register_file_mode_switch_tb;
  import brfms_pkg::*;

  localparam int RandomItems = 950;
  localparam int QuietFrom   = 820;
  localparam int StallLimit  = 400;
  localparam int DrainCycles = 12;

  // Kind codes that the block treats as no operation.
  localparam logic [2:0] KindSpareLo = 3'd5;
  localparam logic [2:0] KindSpareHi = 3'd7;

  // Mode codes that name no processor mode.
  localparam logic [4:0] ModeBadZero = 5'h00;
  localparam logic [4:0] ModeBadHigh = 5'h1E;

  typedef struct packed {
    logic [31:0] rd;
    logic [4:0]  mode;
    logic        err;
  } outcome_t;

  typedef struct {
    logic [2:0]  kind;
    logic [3:0]  idx;
    logic [31:0] val;
    logic [4:0]  mode;
    bit          typed;
    outcome_t    want;
  } access_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  kind;
  logic [3:0]  reg_index;
  logic [31:0] write_value;
  logic [4:0]  target_mode;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] read_value;
  logic [4:0]  mode_now;
  logic        error;

  banked_register_file_mode_switch uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .kind(kind),
    .reg_index(reg_index),
    .write_value(write_value),
    .target_mode(target_mode),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .read_value(read_value),
    .mode_now(mode_now),
    .error(error)
  );

  // Shadow copy of the register file as the block should hold it.
  logic [31:0] arch_regs [NumRegs];
  logic [31:0] fiq_shadow [NumHigh];
  logic [31:0] sp_bank [NumBanks];
  logic [31:0] lr_bank [NumBanks];
  logic [31:0] spsr_bank [NumSaved];
  logic [31:0] spsr_live;
  logic [4:0]  mode_live;

  logic [4:0] valid_modes [7] = '{MODE_USR, MODE_FIQ, MODE_IRQ, MODE_SVC,
                                  MODE_ABT, MODE_UND, MODE_SYS};

  outcome_t pending_results [$];
  outcome_t oldest_result;
  access_t  script [$];
  access_t  item;
  int       mismatches = 0;
  int       quiet_cycles = 0;
  int       stall_left = 0;
  bit       calm = 1'b0;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Bank group of a mode code; -1 marks a code that names no mode.
  function automatic int bank_of(logic [4:0] m);
    case (m)
      MODE_USR, MODE_SYS: return 0;
      MODE_FIQ: return 1;
      MODE_IRQ: return 2;
      MODE_SVC: return 3;
      MODE_ABT: return 4;
      MODE_UND: return 5;
      default: return -1;
    endcase
  endfunction

  task automatic load_start_values();
    foreach (arch_regs[i]) arch_regs[i] = '0;
    foreach (fiq_shadow[i]) fiq_shadow[i] = '0;
    foreach (sp_bank[i]) sp_bank[i] = '0;
    foreach (lr_bank[i]) lr_bank[i] = '0;
    foreach (spsr_bank[i]) spsr_bank[i] = '0;
    spsr_live = '0;
    mode_live = MODE_SYS;
    arch_regs[0] = RST_PC;
    arch_regs[1] = RST_R1;
    arch_regs[13] = RST_SP;
    arch_regs[15] = RST_PC;
  endtask

  // Applies one access to the shadow file and returns the result it gives.
  function automatic outcome_t execute_access(logic [2:0] k, logic [3:0] idx,
                                              logic [31:0] val, logic [4:0] m);
    outcome_t res;
    int src;
    int dst;
    logic [31:0] tmp;
    res = '0;
    src = bank_of(mode_live);
    case (k)
      K_READ_REG: res.rd = arch_regs[idx];
      K_WRITE_REG: arch_regs[idx] = val;
      K_MODE: begin
        dst = bank_of(m);
        if (dst < 0) begin
          res.err = 1'b1;
        end else if (m != mode_live) begin
          if (src < 0) src = 0;
          sp_bank[src] = arch_regs[13];
          lr_bank[src] = arch_regs[14];
          if (src > 0) spsr_bank[src - 1] = spsr_live;
          // Only a move into or out of FIQ trades r8 to r12.
          if ((mode_live == MODE_FIQ) != (m == MODE_FIQ)) begin
            for (int i = 0; i < NumHigh; i++) begin
              tmp = arch_regs[8 + i];
              arch_regs[8 + i] = fiq_shadow[i];
              fiq_shadow[i] = tmp;
            end
          end
          arch_regs[13] = sp_bank[dst];
          arch_regs[14] = lr_bank[dst];
          if (dst > 0) spsr_live = spsr_bank[dst - 1];
          mode_live = m;
        end
      end
      K_READ_SPSR: begin
        if (src > 0) res.rd = spsr_live;
        else res.err = 1'b1;
      end
      K_WRITE_SPSR: begin
        if (src > 0) spsr_live = val;
        else res.err = 1'b1;
      end
      default: ;
    endcase
    res.mode = mode_live;
    return res;
  endfunction

  task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: %s mismatch: got %h, want %h", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic add_row(logic [2:0] k, logic [3:0] idx, logic [31:0] val,
                         logic [4:0] m, bit typed = 1'b0, outcome_t want = '0);
    access_t r;
    r.kind = k;
    r.idx = idx;
    r.val = val;
    r.mode = m;
    r.typed = typed;
    r.want = want;
    script.push_back(r);
  endtask

  function automatic access_t random_access();
    access_t r;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 30) r.kind = K_READ_REG;
    else if (pick < 55) r.kind = K_WRITE_REG;
    else if (pick < 75) r.kind = K_MODE;
    else if (pick < 85) r.kind = K_READ_SPSR;
    else if (pick < 95) r.kind = K_WRITE_SPSR;
    else r.kind = 3'($urandom_range(KindSpareLo, KindSpareHi));
    r.idx = 4'($urandom_range(0, 15));
    case ($urandom_range(0, 7))
      0: r.val = '0;
      1: r.val = '1;
      default: r.val = $urandom;
    endcase
    // Most mode changes name a real mode so the banks get exercised.
    if ($urandom_range(0, 99) < 85) r.mode = valid_modes[$urandom_range(0, 6)];
    else r.mode = 5'($urandom_range(0, 31));
    r.typed = 1'b0;
    r.want = '0;
    return r;
  endfunction

  // Presents one item, records its expected result, and returns after it is taken.
  task automatic send_access(access_t r);
    outcome_t res;
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= r.kind;
    reg_index <= r.idx;
    write_value <= r.val;
    target_mode <= r.mode;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    res = execute_access(r.kind, r.idx, r.val, r.mode);
    pending_results.push_back(r.typed ? r.want : res);
    @(posedge clk);
  endtask

  // Result receiver with random stall bursts, always ready while calm.
  always @(posedge clk) begin
    if (calm) begin
      out_ready <= 1'b1;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 4) == 0) begin
      out_ready <= 1'b0;
      stall_left <= $urandom_range(0, 3);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Signals are stable at the falling edge, so handshakes are judged there.
  always @(negedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("Regression FAIL");
        $finish;
      end
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          flag_mismatch("result with nothing pending", read_value, '0);
        end else begin
          oldest_result = pending_results.pop_front();
          if (read_value !== oldest_result.rd)
            flag_mismatch("read_value", read_value, oldest_result.rd);
          if (mode_now !== oldest_result.mode)
            flag_mismatch("mode_now", 32'(mode_now), 32'(oldest_result.mode));
          if (error !== oldest_result.err)
            flag_mismatch("error", 32'(error), 32'(oldest_result.err));
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    out_ready = 1'b0;
    kind = '0;
    reg_index = '0;
    write_value = '0;
    target_mode = '0;
    load_start_values();

    // Start values, saved status outside exception modes, bad and same mode.
    add_row(K_READ_REG, 4'd0, '0, MODE_SYS, 1'b1, '{RST_PC, MODE_SYS, 1'b0});
    add_row(K_READ_REG, 4'd1, '1, MODE_SYS, 1'b1, '{RST_R1, MODE_SYS, 1'b0});
    add_row(K_READ_REG, 4'd13, '0, MODE_SYS, 1'b1, '{RST_SP, MODE_SYS, 1'b0});
    add_row(K_READ_REG, 4'd15, '0, MODE_SYS, 1'b1, '{RST_PC, MODE_SYS, 1'b0});
    add_row(K_READ_SPSR, 4'd0, '0, MODE_SYS, 1'b1, '{32'h0, MODE_SYS, 1'b1});
    add_row(K_WRITE_SPSR, 4'd0, '1, MODE_SYS, 1'b1, '{32'h0, MODE_SYS, 1'b1});
    add_row(K_MODE, 4'd0, '0, ModeBadZero, 1'b1, '{32'h0, MODE_SYS, 1'b1});
    add_row(K_MODE, 4'd0, '0, MODE_SYS, 1'b1, '{32'h0, MODE_SYS, 1'b0});
    // User and system share a bank; then through FIQ and back out.
    add_row(K_WRITE_REG, 4'd8, '1, MODE_SYS);
    add_row(K_WRITE_REG, 4'd13, '1, MODE_SYS);
    add_row(K_MODE, 4'd0, '0, MODE_USR, 1'b1, '{32'h0, MODE_USR, 1'b0});
    add_row(K_READ_REG, 4'd13, '0, MODE_USR);
    add_row(K_MODE, 4'd0, '0, MODE_FIQ);
    add_row(K_READ_REG, 4'd8, '0, MODE_FIQ);
    add_row(K_WRITE_REG, 4'd8, 32'h1234_5678, MODE_FIQ);
    add_row(K_WRITE_SPSR, 4'd0, '1, MODE_FIQ);
    add_row(K_READ_SPSR, 4'd0, '0, MODE_FIQ);
    add_row(K_MODE, 4'd0, '0, MODE_IRQ);
    add_row(K_READ_REG, 4'd8, '0, MODE_IRQ);
    add_row(K_READ_SPSR, 4'd0, '0, MODE_IRQ);
    // Remaining exception modes, a bad code and a spare kind in undefined mode.
    add_row(K_MODE, 4'd0, '0, MODE_SVC);
    add_row(K_MODE, 4'd0, '0, MODE_ABT);
    add_row(K_MODE, 4'd0, '0, MODE_UND);
    add_row(K_WRITE_REG, 4'd15, '1, MODE_UND);
    add_row(K_MODE, 4'd0, '0, ModeBadHigh, 1'b1, '{32'h0, MODE_UND, 1'b1});
    add_row(KindSpareHi, 4'd15, '1, MODE_SYS, 1'b1, '{32'h0, MODE_UND, 1'b0});
    add_row(K_MODE, 4'd0, '0, MODE_FIQ);
    add_row(K_READ_SPSR, 4'd0, '0, MODE_FIQ);

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (script[i]) send_access(script[i]);

    // Random part: calm stretches now and then, and calm throughout near the end.
    for (int n = 0; n < RandomItems; n++) begin
      calm = (n >= QuietFrom) || ((n / 100) % 4 == 3);
      item = random_access();
      send_access(item);
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
